/* design/cpt_pkg.sv */
// shared types, command codes and prescaler table for the timer bank
// no dependencies; used by cpt_timer and cascadable_prescaled_timer_bank_core
package cpt_pkg;

    // number of timers in the bank (up to 4, the reach of the 2-bit timer index)
    localparam int NUM_TIMERS = 4;

    // timers whose flags fit in the result masks
    localparam int MASK_W = 4;

    localparam int CNT_W = 16;
    localparam int PRE_W = 11;
    localparam int CTL_W = 8;

    // control word layout
    localparam int CTL_PRE_LO = 0;
    localparam int CTL_PRE_HI = 1;
    localparam int CTL_CASCADE = 2;
    localparam int CTL_IRQ = 6;
    localparam int CTL_START = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WR_CTL = 2'd1,
        CMD_WR_RLD = 2'd2,
        CMD_RD_CNT = 2'd3
    } t_cpt_cmd;

    typedef struct packed {
        t_cpt_cmd    cmd;
        logic [1:0]  timer_index;
        logic [15:0] write_data;
    } t_cpt_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  overflow_mask;
        logic [3:0]  irq_mask;
    } t_cpt_out;

    // per-timer strobes from the bank to one timer
    typedef struct packed {
        logic             tick;
        logic             wr_ctl;
        logic             wr_rld;
        logic [CNT_W-1:0] data;
    } t_tmr_req;

    // per-timer status back to the bank
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic             irq;
    } t_tmr_stat;

    // prescaler terminal count: divide by 1, 64, 256 or 1024
    function automatic logic [PRE_W:0] div_limit(input logic [1:0] sel);
        logic [PRE_W:0] lim;
        case (sel)
            2'd0:    lim = 12'd1;
            2'd1:    lim = 12'd64;
            2'd2:    lim = 12'd256;
            2'd3:    lim = 12'd1024;
            default: lim = 12'd1;
        endcase
        return lim;
    endfunction

endpackage

/* design/cascadable_prescaled_timer_bank_core.sv */
// bank of cascadable prescaled 16-bit timers with an input and a result register
// depends on cpt_pkg and cpt_timer
//
// usage: each transfer on the input channel (i_in_valid, o_in_stall, i_in_data)
// is a tick, a control write, a reload write or a counter read. every transfer
// yields exactly one result transfer on the output channel (o_out_valid,
// i_out_stall, o_out_data) in the same order.
// a transfer taken into the input register is processed into the result register,
// which presents its result until the receiver takes it.
// throughput: one transfer per cycle while the receiver does not stall; the cascade
// chain across the timers is resolved combinationally as the transfer is processed.
// reset (i_rst_n low at a rising edge): all timers stop, counters, reload
// values and prescalers clear, and both registers empty.
// when the receiver stalls, the result register holds its transfer; an empty
// input register still takes one more transfer, and while the input register
// is full o_in_stall stays high until the result is taken.
module cascadable_prescaled_timer_bank_core
    import cpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_cpt_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_cpt_out o_out_data
);

    logic     r_in_valid;
    t_cpt_in  r_in;
    logic     r_out_valid;
    t_cpt_out r_out, n_out;

    logic      out_ready;
    logic      proc;
    logic      take_in;
    t_tmr_req  req  [NUM_TIMERS];
    t_tmr_stat stat [NUM_TIMERS];
    logic      below [NUM_TIMERS];

    // handshake
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign take_in    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_data;
        end
    end

    // timer lanes with the overflow chain
    for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_tmr
        logic sel;
        assign sel = (32'(r_in.timer_index) == j);

        always_comb begin
            req[j].tick   = proc && (r_in.cmd == CMD_TICK);
            req[j].wr_ctl = proc && (r_in.cmd == CMD_WR_CTL) && sel;
            req[j].wr_rld = proc && (r_in.cmd == CMD_WR_RLD) && sel;
            req[j].data   = r_in.write_data;
        end

        if (j == 0) begin : g_first
            assign below[j] = 1'b0;
        end else begin : g_rest
            assign below[j] = stat[j-1].ovf;
        end

        cpt_timer u_tmr (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_chain_en  ((j != 0) ? 1'b1 : 1'b0),
            .i_below_ovf (below[j]),
            .i_req       (req[j]),
            .o_stat      (stat[j])
        );
    end

    // result assembly
    always_comb begin
        n_out = '0;
        for (int j = 0; j < NUM_TIMERS; j++) begin
            if (r_in.cmd == CMD_RD_CNT && 32'(r_in.timer_index) == j) begin
                n_out.read_data = stat[j].count;
            end
            if (j < MASK_W && r_in.cmd == CMD_TICK) begin
                n_out.overflow_mask[j] = stat[j].ovf;
                n_out.irq_mask[j]      = stat[j].irq;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an interrupt flag never appears without its overflow flag
    a_irq_in_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.irq_mask & ~r_out.overflow_mask) == '0))
        else $error("irq flag without overflow");

    // items other than ticks carry empty masks
    a_nontick_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_in.cmd != CMD_TICK)
        |=> (r_out.overflow_mask == '0) && (r_out.irq_mask == '0))
        else $error("masks set on a non-tick transfer");

    // items other than reads carry zero read data
    a_nonread_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_in.cmd != CMD_RD_CNT) |=> (r_out.read_data == '0))
        else $error("read data set on a non-read transfer");

    // a held input item is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_ready |=> r_in_valid && $stable(r_in))
        else $error("held input item lost");

endmodule

/* design/cpt_timer.sv */
// one 16-bit timer: counter, reload, control and prescaler state
// depends on cpt_pkg; instantiated once per timer by the bank core
module cpt_timer
    import cpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_chain_en,
    input  logic      i_below_ovf,
    input  t_tmr_req  i_req,
    output t_tmr_stat o_stat
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_rld, n_rld;
    logic [CTL_W-1:0] r_ctl, n_ctl;
    logic [PRE_W-1:0] r_pre, n_pre;

    logic             started;
    logic             cascaded;
    logic [PRE_W:0]   pre_inc;
    logic             pre_hit;
    logic             inc;
    logic             ovf;

    // increment decision for a tick
    always_comb begin
        started  = r_ctl[CTL_START];
        cascaded = r_ctl[CTL_CASCADE] && i_chain_en;
        pre_inc  = {1'b0, r_pre} + {{PRE_W{1'b0}}, 1'b1};
        pre_hit  = pre_inc >= div_limit(r_ctl[CTL_PRE_HI:CTL_PRE_LO]);
        inc      = i_req.tick && started && (cascaded ? i_below_ovf : pre_hit);
        ovf      = inc && (r_cnt == CNT_MAX);
    end

    // next state for tick, control write and reload write
    always_comb begin
        n_cnt = r_cnt;
        n_rld = r_rld;
        n_ctl = r_ctl;
        n_pre = r_pre;
        if (i_req.tick) begin
            if (started && !cascaded) begin
                n_pre = pre_hit ? '0 : pre_inc[PRE_W-1:0];
            end
            if (inc) begin
                n_cnt = ovf ? r_rld : r_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
            end
        end
        if (i_req.wr_ctl) begin
            n_ctl = i_req.data[CTL_W-1:0];
            n_pre = '0;
            if (!started && i_req.data[CTL_START]) begin
                n_cnt = r_rld;
            end
        end
        if (i_req.wr_rld) begin
            n_rld = i_req.data;
        end
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rld <= '0;
            r_ctl <= '0;
            r_pre <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_rld <= n_rld;
            r_ctl <= n_ctl;
            r_pre <= n_pre;
        end
    end

    assign o_stat.count = r_cnt;
    assign o_stat.ovf   = ovf;
    assign o_stat.irq   = ovf && r_ctl[CTL_IRQ];

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for cascadable_prescaled_timer_bank_core
// depends on cpt_pkg and the core; predicts each result transfer and checks it in order
`timescale 1ns / 100ps

module testbench;
    import cpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        STALL_NONE   = 2'd0,
        STALL_LIGHT  = 2'd1,
        STALL_HEAVY  = 2'd2,
        STALL_TOGGLE = 2'd3
    } t_stall_mode;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_cpt_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_cpt_out out_data;

    cascadable_prescaled_timer_bank_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // predicted timer bank state
    logic [CNT_W-1:0] tmr_count    [NUM_TIMERS] = '{default: '0};
    logic [CNT_W-1:0] tmr_reload   [NUM_TIMERS] = '{default: '0};
    logic [CTL_W-1:0] tmr_ctl      [NUM_TIMERS] = '{default: '0};
    logic [PRE_W-1:0] tmr_prescale [NUM_TIMERS] = '{default: '0};

    t_cpt_out    pending_results[$];
    t_cpt_out    want;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  stall_phase = '0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cascadable_prescaled_timer_bank_core regression: fail");
            $finish;
        end
    end

    function automatic logic [PRE_W:0] prescale_period(input logic [1:0] sel);
        case (sel)
            2'd0:    return 12'd1;
            2'd1:    return 12'd64;
            2'd2:    return 12'd256;
            default: return 12'd1024;
        endcase
    endfunction

    // advance every started timer by one tick, cascades resolved bottom up
    function automatic void tick_bank(output logic [3:0] ovf, output logic [3:0] irq);
        logic           below_ovf;
        logic           this_ovf;
        logic           bump;
        logic [PRE_W:0] pc;
        int             i;
        below_ovf = 1'b0;
        ovf = '0;
        irq = '0;
        for (i = 0; i < NUM_TIMERS; i++) begin
            this_ovf = 1'b0;
            if (tmr_ctl[i][CTL_START]) begin
                bump = 1'b0;
                if (tmr_ctl[i][CTL_CASCADE] && i != 0) begin
                    bump = below_ovf;
                end else begin
                    pc = {1'b0, tmr_prescale[i]} + 1'b1;
                    if (pc >= prescale_period(tmr_ctl[i][CTL_PRE_HI:CTL_PRE_LO])) begin
                        pc = '0;
                        bump = 1'b1;
                    end
                    tmr_prescale[i] = pc[PRE_W-1:0];
                end
                if (bump) begin
                    if (tmr_count[i] == CNT_MAX) begin
                        this_ovf = 1'b1;
                        tmr_count[i] = tmr_reload[i];
                        if (i < MASK_W) begin
                            ovf[i] = 1'b1;
                            irq[i] = tmr_ctl[i][CTL_IRQ];
                        end
                    end else begin
                        tmr_count[i] = tmr_count[i] + 1'b1;
                    end
                end
            end
            below_ovf = this_ovf;
        end
    endfunction

    // expected result of one transfer, updating the predicted state
    function automatic t_cpt_out predict_timer_bank(input t_cpt_in item);
        t_cpt_out   res;
        logic [3:0] ovf;
        logic [3:0] irq;
        int         idx;
        logic       was_started;
        res = '0;
        idx = int'(item.timer_index);
        case (item.cmd)
            CMD_TICK: begin
                tick_bank(ovf, irq);
                res.overflow_mask = ovf;
                res.irq_mask = irq;
            end
            CMD_WR_CTL: begin
                if (idx < NUM_TIMERS) begin
                    was_started = tmr_ctl[idx][CTL_START];
                    tmr_ctl[idx] = item.write_data[CTL_W-1:0];
                    tmr_prescale[idx] = '0;
                    if (!was_started && tmr_ctl[idx][CTL_START])
                        tmr_count[idx] = tmr_reload[idx];
                end
            end
            CMD_WR_RLD: begin
                if (idx < NUM_TIMERS)
                    tmr_reload[idx] = item.write_data;
            end
            default: begin
                if (idx < NUM_TIMERS)
                    res.read_data = tmr_count[idx];
            end
        endcase
        return res;
    endfunction

    function automatic t_cpt_in bank_op(input t_cpt_cmd cmd, input int idx,
                                        input logic [15:0] data);
        t_cpt_in item;
        item.cmd = cmd;
        item.timer_index = idx[1:0];
        item.write_data = data;
        return item;
    endfunction

    function automatic logic [15:0] ctl_word(input bit start, input bit irq_en,
                                             input bit cascade, input logic [1:0] pre);
        logic [15:0] w;
        w = '0;
        w[CTL_START] = start;
        w[CTL_IRQ] = irq_en;
        w[CTL_CASCADE] = cascade;
        w[CTL_PRE_HI:CTL_PRE_LO] = pre;
        return w;
    endfunction

    // send one transfer in bursts with random gaps, record its expected result
    task automatic send_transfer(input t_cpt_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(predict_timer_bank(item));
    endtask

    task automatic issue(input t_cpt_cmd cmd, input int idx, input logic [15:0] data);
        send_transfer(bank_op(cmd, idx, data));
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // counters read zero and ticks do nothing while all timers are stopped
    task automatic test_reset_state();
        int i;
        for (i = 0; i < NUM_TIMERS; i++) issue(CMD_RD_CNT, i, 16'hFFFF);
        issue(CMD_TICK, 0, 16'h0000);
    endtask

    // overflow and interrupt on timer 0, cascade bit ignored there, upper bits ignored
    task automatic test_overflow_irq();
        issue(CMD_WR_RLD, 0, 16'hFFFF);
        issue(CMD_WR_CTL, 0, 16'hFF00 | ctl_word(1, 1, 1, 2'd0));
        issue(CMD_TICK, 2, 16'hFFFF);
        issue(CMD_RD_CNT, 0, 16'h0000);
        issue(CMD_TICK, 0, 16'h0000);
    endtask

    // cascade from timer 0, cascade above a stopped timer, writes to running timers
    task automatic test_cascade_chain();
        issue(CMD_WR_RLD, 1, 16'hFFFE);
        issue(CMD_WR_CTL, 1, ctl_word(1, 0, 1, 2'd3));
        issue(CMD_WR_RLD, 3, 16'hFFFF);
        issue(CMD_WR_CTL, 3, ctl_word(1, 1, 1, 2'd0));
        issue(CMD_TICK, 0, 16'h0000);
        issue(CMD_TICK, 0, 16'h0000);
        issue(CMD_TICK, 0, 16'h0000);
        issue(CMD_RD_CNT, 1, 16'h0000);
        issue(CMD_RD_CNT, 3, 16'h0000);
        // reload write and control write leave a running counter alone
        issue(CMD_WR_RLD, 0, 16'h1234);
        issue(CMD_WR_CTL, 0, ctl_word(1, 0, 0, 2'd0));
        issue(CMD_RD_CNT, 0, 16'h0000);
        issue(CMD_WR_CTL, 0, 16'h0000);
        issue(CMD_WR_CTL, 2, 16'hFFFF);
        issue(CMD_TICK, 0, 16'h0000);
    endtask

    // each prescaler overflows exactly after its period, control write clears it
    task automatic test_prescalers();
        int i;
        for (i = 0; i < NUM_TIMERS; i++) issue(CMD_WR_CTL, i, 16'h0000);
        for (i = 0; i < NUM_TIMERS; i++) issue(CMD_WR_RLD, i, 16'hFFFF);
        // timers 0 to 2 divide by 64, 256 and 1024, timer 3 counts overflows of timer 2
        issue(CMD_WR_CTL, 0, ctl_word(1, 1, 0, 2'd1));
        issue(CMD_WR_CTL, 1, ctl_word(1, 1, 0, 2'd2));
        issue(CMD_WR_CTL, 2, ctl_word(1, 1, 0, 2'd3));
        issue(CMD_WR_CTL, 3, ctl_word(1, 1, 1, 2'd0));
        // restart the divide by 64 part way through its period
        repeat (40) issue(CMD_TICK, 0, 16'h0000);
        issue(CMD_WR_CTL, 0, ctl_word(1, 1, 0, 2'd1));
        repeat (1024 - 40) issue(CMD_TICK, 0, 16'h0000);
        for (i = 0; i < NUM_TIMERS; i++) issue(CMD_RD_CNT, i, 16'h0000);
        for (i = 0; i < NUM_TIMERS; i++) issue(CMD_WR_CTL, i, 16'h0000);
    endtask

    function automatic logic [15:0] random_control();
        logic [15:0] w;
        w = 16'($urandom);
        w[CTL_START] = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) != 0)
            w[CTL_PRE_HI:CTL_PRE_LO] = 2'd0;
        return w;
    endfunction

    // mostly configure-then-run sequences, some fully random noise
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          k;
        int          n;
        int          idx;
        logic [15:0] rld;
        bit          drained;
        sent = 0;
        drained = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    idx = $urandom_range(0, NUM_TIMERS - 1);
                    rld = ($urandom_range(0, 3) != 0)
                          ? 16'hFFFF - 16'($urandom_range(0, 15))
                          : 16'($urandom);
                    issue(CMD_WR_RLD, idx, rld);
                    if ($urandom_range(0, 2) == 0) begin
                        issue(CMD_WR_CTL, idx, random_control() & ~ctl_word(1, 0, 0, 2'd0));
                        sent++;
                    end
                    issue(CMD_WR_CTL, idx, random_control());
                    sent += 2;
                end
                n = $urandom_range(1, 40);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        issue(CMD_RD_CNT, $urandom_range(0, 3), 16'($urandom));
                    else
                        issue(CMD_TICK, $urandom_range(0, 3), 16'($urandom));
                end
                sent += n;
            end else begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    issue(t_cpt_cmd'($urandom_range(0, 3)), $urandom_range(0, 3),
                          16'($urandom));
                sent += n;
            end
            if (!drained && sent > n_items / 2) begin
                wait_all_results();
                drained = 1;
            end
        end
    endtask

    // receiver stall pattern, with a new random mode each time the low six phase bits wrap
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase[5:0] == 6'd0)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            default:      out_stall <= stall_phase[1];
        endcase
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", out_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
                    mismatch_count++;
                end
                if (out_data.overflow_mask !== want.overflow_mask) begin
                    $error("overflow_mask: expected %b, got %b",
                           want.overflow_mask, out_data.overflow_mask);
                    mismatch_count++;
                end
                if (out_data.irq_mask !== want.irq_mask) begin
                    $error("irq_mask: expected %b, got %b", want.irq_mask, out_data.irq_mask);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_overflow_irq();
        test_cascade_chain();
        wait_all_results();
        test_prescalers();
        wait_all_results();
        test_random_traffic(200);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("cascadable_prescaled_timer_bank_core regression: pass");
        end else begin
            $display("cascadable_prescaled_timer_bank_core regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/cpt_pkg.sv
design/cpt_timer.sv
design/cascadable_prescaled_timer_bank_core.sv
tb/sv/testbench.sv
